// ===== sv/sbpr_pkg.sv =====
// Shared types and constants of the spectral bin phase rotator.
package sbpr_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_PHASE_ANGLE = 2'd0;
  localparam logic [1:0] REG_MIX_AMOUNT  = 2'd1;
  localparam logic [1:0] REG_PHASE_STYLE = 2'd2;

  // Phase style codes
  localparam logic [2:0] STYLE_NORMAL       = 3'd0;
  localparam logic [2:0] STYLE_EVEN_ODD     = 3'd1;
  localparam logic [2:0] STYLE_HARMONIC     = 3'd2;
  localparam logic [2:0] STYLE_HARMONIC_EO  = 3'd3;
  localparam logic [2:0] STYLE_CLEAR        = 3'd4;

  // What the pipeline does with a bin
  localparam logic [1:0] MODE_PASS   = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_ROTATE = 2'd2;

  localparam logic [16:0] MIX_ONE  = 17'd65536;
  localparam logic [31:0] ONE_Q30  = 32'd1073741824;
  localparam logic [23:0] MAG_MAX  = 24'd8388607;

  // Sine polynomial coefficients, Q30, innermost term first
  localparam logic [31:0] SINE_C13 = 32'd61;
  localparam logic [31:0] SINE_COEF [6] = '{
    32'd3864, 32'd172272, 32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
  };

  typedef struct packed {
    logic [15:0] phase_angle;
    logic [16:0] mix_amount;
    logic [2:0]  phase_style;
  } cfg_t;

endpackage

// ===== sv/sbpr_bin_if.sv =====
// Input bin channel.
interface sbpr_bin_if;
  logic               valid;
  logic               ready;
  logic [10:0]        bin_index;
  logic signed [23:0] bin_real;
  logic signed [23:0] bin_imag;

  modport source (output valid, bin_index, bin_real, bin_imag, input ready);
  modport sink (input valid, bin_index, bin_real, bin_imag, output ready);
endinterface

// ===== sv/sbpr_out_if.sv =====
// Result bin channel.
interface sbpr_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] out_real;
  logic signed [23:0] out_imag;

  modport source (output valid, out_real, out_imag, input ready);
  modport sink (input valid, out_real, out_imag, output ready);
endinterface

// ===== sv/sbpr_cfg_if.sv =====
// Configuration write channel.
interface sbpr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [16:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/spectral_bin_phase_rotator.sv =====
// Top level of the spectral bin phase rotator.
//
// Usage:
//   bin  - input channel: bin_index, bin_real, bin_imag (Q1.23).
//   res  - result channel: out_real, out_imag (Q1.23, saturated).
//   cfg  - register writes: 0 phase_angle, 1 mix_amount, 2 phase_style.
//          Always ready; write only while no bin is in flight.
// Throughput is one bin per cycle while the receiver takes results; the depth
// is set by the sine polynomial, a chain of eight multiplies, each with its
// own register stage, followed by three stages of rotation and blending. The
// clear style runs the magnitude through a 24-digit square root, three digits
// per stage, in parallel. Reset clears all valid bits and loads the register
// defaults (angle 0, mix full, style normal). When the receiver stalls, the
// whole pipeline holds and bin.ready drops in the same cycle; nothing is lost
// or repeated.
module spectral_bin_phase_rotator #(
  parameter int WAVEFORM_SIZE = 2048
) (
  input  logic       clk,
  input  logic       rst,
  sbpr_bin_if.sink   bin,
  sbpr_out_if.source res,
  sbpr_cfg_if.sink   cfg
);
  import sbpr_pkg::*;

  localparam int LAST = 13;

  cfg_t               regs;
  logic               en;
  logic [LAST+1:1]    vld;
  logic [1:0]         md   [1:LAST];
  logic signed [23:0] re_q [1:LAST];
  logic signed [23:0] im_q [1:LAST];
  logic [10:0]        k_q;
  logic [1:0]         mode_in;

  logic [15:0]        a_sin, a_cos;
  logic signed [31:0] s, c;
  logic signed [23:0] rot_re, rot_im;
  logic [23:0]        mag;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.phase_angle <= 16'd0;
      regs.mix_amount  <= MIX_ONE;
      regs.phase_style <= STYLE_NORMAL;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PHASE_ANGLE: regs.phase_angle <= cfg.data[15:0];
        REG_MIX_AMOUNT:  regs.mix_amount  <= cfg.data;
        REG_PHASE_STYLE: regs.phase_style <= cfg.data[2:0];
        default: ;
      endcase
    end
  end

  // Advance the pipeline unless the result is held
  assign en        = !vld[LAST+1] || res.ready;
  assign bin.ready = en;
  assign res.valid = vld[LAST+1];

  // Classify the bin at entry
  always_comb begin
    if (32'(bin.bin_index) >= 32'(WAVEFORM_SIZE) || regs.phase_style > STYLE_CLEAR) begin
      mode_in = MODE_PASS;
    end else if (regs.phase_style == STYLE_CLEAR) begin
      mode_in = MODE_CLEAR;
    end else begin
      mode_in = MODE_ROTATE;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST:1], bin.valid};
    end
  end

  // Side data travels with the valid bits
  always_ff @(posedge clk) begin
    if (en) begin
      md[1]   <= mode_in;
      re_q[1] <= bin.bin_real;
      im_q[1] <= bin.bin_imag;
      k_q     <= bin.bin_index;
      for (int i = 2; i <= LAST; i++) begin
        md[i]   <= md[i-1];
        re_q[i] <= re_q[i-1];
        im_q[i] <= im_q[i-1];
      end
    end
  end

  sbpr_angle u_angle (
    .clk(clk), .en(en), .cfg(regs), .k(k_q), .a_sin(a_sin), .a_cos(a_cos)
  );

  sbpr_sine u_sin (.clk(clk), .en(en), .ang(a_sin), .sine(s));
  sbpr_sine u_cos (.clk(clk), .en(en), .ang(a_cos), .sine(c));

  sbpr_rotmix u_rotmix (
    .clk(clk), .en(en), .cfg(regs), .s(s), .c(c),
    .re(re_q[10]), .im(im_q[10]), .res_re(rot_re), .res_im(rot_im)
  );

  sbpr_isqrt u_isqrt (
    .clk(clk), .en(en), .re(re_q[1]), .im(im_q[1]), .mag(mag)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      unique case (md[LAST])
        MODE_CLEAR: begin
          res.out_real <= signed'(mag);
          res.out_imag <= 24'sd0;
        end
        MODE_ROTATE: begin
          res.out_real <= rot_re;
          res.out_imag <= rot_im;
        end
        default: begin
          res.out_real <= re_q[LAST];
          res.out_imag <= im_q[LAST];
        end
      endcase
    end
  end
endmodule

// ===== sv/sbpr_angle.sv =====
// Rotation angle from bin index, phase step and style.
module sbpr_angle (
  input  logic          clk,
  input  logic          en,
  input  sbpr_pkg::cfg_t cfg,
  input  logic [10:0]   k,
  output logic [15:0]   a_sin,
  output logic [15:0]   a_cos
);
  import sbpr_pkg::*;

  logic [26:0] kp_full;
  logic [15:0] kp;
  logic [15:0] ang;

  // Pick the signed step for the style
  always_comb begin
    kp_full = 27'(k) * 27'(cfg.phase_angle);
    kp      = kp_full[15:0];
    unique case (cfg.phase_style)
      STYLE_NORMAL:      ang = 16'd0 - kp;
      STYLE_EVEN_ODD:    ang = k[0] ? kp : 16'd0 - kp;
      STYLE_HARMONIC:    ang = 16'd0 - cfg.phase_angle;
      STYLE_HARMONIC_EO: ang = k[0] ? cfg.phase_angle : 16'd0 - cfg.phase_angle;
      default:           ang = 16'd0;
    endcase
  end

  // Register sine and cosine angles
  always_ff @(posedge clk) begin
    if (en) begin
      a_sin <= ang;
      a_cos <= ang + 16'd16384;
    end
  end
endmodule

// ===== sv/sbpr_sine.sv =====
// Pipelined sine of a 16-bit turn angle, Q30 result, eight stages.
module sbpr_sine (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        ang,
  output logic signed [31:0] sine
);
  import sbpr_pkg::*;

  logic [30:0] x_q   [0:6];
  logic [30:0] y_q   [0:5];
  logic        neg_q [0:6];
  logic [31:0] p_q   [0:5];

  logic [14:0] arg;
  logic [30:0] x0;
  logic [61:0] xx;
  logic [62:0] fp;
  logic [31:0] v;

  // Fold into the first quadrant and square the argument
  always_comb begin
    arg = ang[14] ? 15'd16384 - {1'b0, ang[13:0]} : {1'b0, ang[13:0]};
    x0  = {arg, 16'b0};
    xx  = 62'(x0) * 62'(x0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_q[0]   <= x0;
      y_q[0]   <= xx[60:30];
      neg_q[0] <= ang[15];
    end
  end

  // Horner steps, one multiply per stage
  for (genvar j = 0; j < 6; j++) begin : g_horner
    logic [31:0] p_in;
    logic [62:0] prod;
    always_comb begin
      p_in = (j == 0) ? SINE_C13 : p_q[(j == 0) ? 0 : j - 1];
      prod = 63'(p_in) * 63'(y_q[j]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        p_q[j]       <= SINE_COEF[j] - prod[61:30];
        x_q[j+1]     <= x_q[j];
        neg_q[j+1]   <= neg_q[j];
      end
    end
    if (j < 5) begin : g_ypass
      always_ff @(posedge clk) begin
        if (en) y_q[j+1] <= y_q[j];
      end
    end
  end

  // Last multiply, cap at one and apply the quadrant sign
  always_comb begin
    fp = 63'(p_q[5]) * 63'(x_q[6]);
    v  = (fp[61:30] > ONE_Q30) ? ONE_Q30 : fp[61:30];
  end

  always_ff @(posedge clk) begin
    if (en) sine <= neg_q[6] ? -signed'(v) : signed'(v);
  end
endmodule

// ===== sv/sbpr_rotmix.sv =====
// Complex rotation and blend with the original bin, three stages.
module sbpr_rotmix (
  input  logic               clk,
  input  logic               en,
  input  sbpr_pkg::cfg_t     cfg,
  input  logic signed [31:0] s,
  input  logic signed [31:0] c,
  input  logic signed [23:0] re,
  input  logic signed [23:0] im,
  output logic signed [23:0] res_re,
  output logic signed [23:0] res_im
);
  import sbpr_pkg::*;

  logic signed [55:0] rc, is, rs, ic;
  logic signed [23:0] re1, im1, re2, im2;
  logic signed [26:0] rre, rim;
  logic signed [44:0] mr, mi;
  logic signed [41:0] wr, wi;

  logic signed [56:0] sum_re, sum_im;
  logic [16:0]        m, w;
  logic signed [45:0] tot_re, tot_im;

  function automatic logic signed [23:0] sat24(input logic signed [29:0] v);
    if (v > 30'sd8388607)       sat24 = 24'sh7FFFFF;
    else if (v < -30'sd8388608) sat24 = 24'sh800000;
    else                        sat24 = v[23:0];
  endfunction

  // Four products of the rotation
  always_ff @(posedge clk) begin
    if (en) begin
      rc  <= 56'(re) * 56'(c);
      is  <= 56'(im) * 56'(s);
      rs  <= 56'(re) * 56'(s);
      ic  <= 56'(im) * 56'(c);
      re1 <= re;
      im1 <= im;
    end
  end

  // Sum and round back to the sample scale
  always_comb begin
    sum_re = 57'(rc) - 57'(is) + 57'sd536870912;
    sum_im = 57'(rs) + 57'(ic) + 57'sd536870912;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rre <= sum_re[56:30];
      rim <= sum_im[56:30];
      re2 <= re1;
      im2 <= im1;
    end
  end

  // Weight rotated and original values
  always_comb begin
    m = (cfg.mix_amount > MIX_ONE) ? MIX_ONE : cfg.mix_amount;
    w = MIX_ONE - m;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mr <= 45'(signed'({1'b0, m})) * 45'(rre);
      mi <= 45'(signed'({1'b0, m})) * 45'(rim);
      wr <= 42'(signed'({1'b0, w})) * 42'(re2);
      wi <= 42'(signed'({1'b0, w})) * 42'(im2);
    end
  end

  // Round, shift and saturate
  always_comb begin
    tot_re = 46'(mr) + 46'(wr) + 46'sd32768;
    tot_im = 46'(mi) + 46'(wi) + 46'sd32768;
    res_re = sat24(tot_re[45:16]);
    res_im = sat24(tot_im[45:16]);
  end
endmodule

// ===== sv/sbpr_isqrt.sv =====
// Pipelined rounded magnitude of a complex bin, twelve stages.
module sbpr_isqrt (
  input  logic               clk,
  input  logic               en,
  input  logic signed [23:0] re,
  input  logic signed [23:0] im,
  output logic [23:0]        mag
);
  localparam int STAGES = 8;
  localparam int PER    = 3;

  logic signed [47:0] sqr, sqi;
  logic [47:0] n_q   [0:STAGES];
  logic [47:0] r_q   [0:STAGES];
  logic [23:0] rnd_q;
  logic [47:0] rnd;

  // Squares, then their sum
  always_ff @(posedge clk) begin
    if (en) begin
      sqr    <= 48'(re) * 48'(re);
      sqi    <= 48'(im) * 48'(im);
      n_q[0] <= 48'(sqr) + 48'(sqi);
      r_q[0] <= 48'd0;
    end
  end

  // Three digit steps per stage
  for (genvar g = 0; g < STAGES; g++) begin : g_digit
    logic [47:0] n_c, r_c, b_c;
    always_comb begin
      n_c = n_q[g];
      r_c = r_q[g];
      for (int j = 0; j < PER; j++) begin
        b_c = 48'(1) << (46 - 2 * (PER * g + j));
        if (n_c >= r_c + b_c) begin
          n_c = n_c - (r_c + b_c);
          r_c = (r_c >> 1) + b_c;
        end else begin
          r_c = r_c >> 1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_q[g+1] <= n_c;
        r_q[g+1] <= r_c;
      end
    end
  end

  // Round to nearest and saturate, then align with the rotation path
  always_comb begin
    rnd = (n_q[STAGES] > r_q[STAGES]) ? r_q[STAGES] + 48'd1 : r_q[STAGES];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd_q <= (rnd > 48'(sbpr_pkg::MAG_MAX)) ? sbpr_pkg::MAG_MAX : rnd[23:0];
      mag   <= rnd_q;
    end
  end
endmodule

// ===== sv/sbpr_checker.sv =====
// Port-level checks of the spectral bin phase rotator.
module sbpr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_real,
  input logic [23:0] out_imag
);
  // A held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_real) && $stable(out_imag))
    else $error("held result changed");

  // Input side stalls only when a result is held
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind spectral_bin_phase_rotator sbpr_checker u_sbpr_checker (
  .clk(clk), .rst(rst), .in_ready(bin.ready), .out_valid(res.valid),
  .out_ready(res.ready), .out_real(res.out_real), .out_imag(res.out_imag)
);
